@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PEAD_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pead assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PEAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pead assertion failed");

`endif

@@ sv/pead_pkg.sv @@
// ----------------------------------------------------------------------------
// Plateau-aware extrema detector package
// Shared widths, mode codes, level counter codes and the stage control type.
// ----------------------------------------------------------------------------
package pead_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COORD_W          = 31;
    localparam int ID_W             = 16;
    localparam int MODE_W           = 2;
    localparam int SEEN_W           = 2;

    localparam logic [MODE_W-1:0] KEEP_ALL      = 2'd0;
    localparam logic [MODE_W-1:0] KEEP_DROP_MIN = 2'd1;
    localparam logic [MODE_W-1:0] KEEP_DROP_MAX = 2'd2;

    localparam logic [SEEN_W-1:0] SEEN_NONE = 2'd0;
    localparam logic [SEEN_W-1:0] SEEN_ONE  = 2'd1;
    localparam logic [SEEN_W-1:0] SEEN_TWO  = 2'd2;

    typedef struct packed {
        logic valid;
        logic record_start;
    } stage_ctl_t;

endpackage

@@ sv/pead_in_stage.sv @@
// ----------------------------------------------------------------------------
// Input register stage
// Captures one sample transfer and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module pead_in_stage #(
    parameter int SAMPLE_WIDTH = pead_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_value,
    input  logic        [pead_pkg::COORD_W-1:0]  coordinate,
    input  logic        [pead_pkg::ID_W-1:0]     sequence_id,
    input  logic                                 record_start,
    input  logic                                 advance,
    output pead_pkg::stage_ctl_t                 stage_ctl,
    output logic signed [SAMPLE_WIDTH-1:0]       stage_value,
    output logic        [pead_pkg::COORD_W-1:0]  stage_coord,
    output logic        [pead_pkg::ID_W-1:0]     stage_id
);
    import pead_pkg::*;

    logic                       valid_reg;
    logic                       valid_next;
    logic                       start_reg;
    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    logic [COORD_W-1:0]         coord_reg;
    logic [ID_W-1:0]            id_reg;
    logic                       load;

    assign sample_ready = !valid_reg || advance;
    assign load         = sample_valid && sample_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= sample_value;
            coord_reg <= coordinate;
            id_reg    <= sequence_id;
            start_reg <= record_start;
        end
    end

    assign stage_ctl.valid        = valid_reg;
    assign stage_ctl.record_start = start_reg;
    assign stage_value            = value_reg;
    assign stage_coord            = coord_reg;
    assign stage_id               = id_reg;

endmodule

@@ sv/pead_core.sv @@
// ----------------------------------------------------------------------------
// Extrema decision core
// Tracks the plateau state, classifies each sample and holds the result.
// ----------------------------------------------------------------------------
module pead_core #(
    parameter int SAMPLE_WIDTH = pead_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic        [pead_pkg::MODE_W-1:0]   cfg_wr_data,
    input  pead_pkg::stage_ctl_t                 stage_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]       stage_value,
    input  logic        [pead_pkg::COORD_W-1:0]  stage_coord,
    input  logic        [pead_pkg::ID_W-1:0]     stage_id,
    output logic                                 advance,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic        [pead_pkg::COORD_W-1:0]  extremum_position,
    output logic signed [SAMPLE_WIDTH-1:0]       extremum_value,
    output logic                                 is_maximum,
    output logic        [pead_pkg::ID_W-1:0]     out_sequence_id
);
    import pead_pkg::*;

    logic [MODE_W-1:0]              mode_reg;
    logic [SEEN_W-1:0]              seen_reg;
    logic [SEEN_W-1:0]              seen_next;
    logic signed [SAMPLE_WIDTH-1:0] before_value_reg;
    logic signed [SAMPLE_WIDTH-1:0] before_value_next;
    logic signed [SAMPLE_WIDTH-1:0] plateau_value_reg;
    logic signed [SAMPLE_WIDTH-1:0] plateau_value_next;
    logic [COORD_W-1:0]             before_coord_reg;
    logic [COORD_W-1:0]             before_coord_next;
    logic [COORD_W-1:0]             last_coord_reg;
    logic [COORD_W-1:0]             last_coord_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [COORD_W-1:0]             pos_reg;
    logic signed [SAMPLE_WIDTH-1:0] val_reg;
    logic                           max_reg;
    logic [ID_W-1:0]                id_reg;

    logic               opens_record;
    logic               extends_plateau;
    logic               peak;
    logic               trough;
    logic               emit;
    logic [COORD_W:0]   coord_sum;

    assign advance = stage_ctl.valid && (!out_valid_reg || result_ready);

    assign opens_record    = stage_ctl.record_start || (seen_reg == SEEN_NONE);
    assign extends_plateau = (stage_value == plateau_value_reg);
    assign peak   = (plateau_value_reg > before_value_reg) && (plateau_value_reg > stage_value);
    assign trough = (plateau_value_reg < before_value_reg) && (plateau_value_reg < stage_value);
    assign emit   = !opens_record && !extends_plateau && (seen_reg == SEEN_TWO)
                    && ((peak && (mode_reg != KEEP_DROP_MAX))
                        || (trough && (mode_reg != KEEP_DROP_MIN)));
    assign coord_sum = {1'b0, before_coord_reg} + {1'b0, stage_coord};

    always_comb
    begin
        seen_next          = seen_reg;
        before_value_next  = before_value_reg;
        plateau_value_next = plateau_value_reg;
        before_coord_next  = before_coord_reg;
        last_coord_next    = last_coord_reg;
        if (advance)
        begin
            priority if (opens_record)
            begin
                seen_next          = SEEN_ONE;
                before_value_next  = stage_value;
                plateau_value_next = stage_value;
                before_coord_next  = stage_coord;
                last_coord_next    = stage_coord;
            end
            else if (extends_plateau)
            begin
                last_coord_next = stage_coord;
            end
            else
            begin
                seen_next          = SEEN_TWO;
                before_value_next  = plateau_value_reg;
                plateau_value_next = stage_value;
                before_coord_next  = last_coord_reg;
                last_coord_next    = stage_coord;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= KEEP_ALL;
            seen_reg          <= SEEN_NONE;
            before_value_reg  <= '0;
            plateau_value_reg <= '0;
            before_coord_reg  <= '0;
            last_coord_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            seen_reg          <= seen_next;
            before_value_reg  <= before_value_next;
            plateau_value_reg <= plateau_value_next;
            before_coord_reg  <= before_coord_next;
            last_coord_reg    <= last_coord_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            pos_reg <= coord_sum[COORD_W:1];
            val_reg <= plateau_value_reg;
            max_reg <= peak;
            id_reg  <= stage_id;
        end
    end

    assign result_valid      = out_valid_reg;
    assign extremum_position = pos_reg;
    assign extremum_value    = val_reg;
    assign is_maximum        = max_reg;
    assign out_sequence_id   = id_reg;

endmodule

@@ sv/plateau_aware_extrema_detector_unit.sv @@
// ----------------------------------------------------------------------------
// Plateau-aware extrema detector
// Streams samples and reports local maxima and minima of plateaus.
// ----------------------------------------------------------------------------
// Samples arrive on the sample channel (sample_valid/sample_ready) with their
// coordinate, sequence id and record start flag. Each transfer may produce at
// most one extremum on the result channel (result_valid/result_ready).
// A sample is registered in the input stage, and the core registers a result
// when it advances past the sample that closed the plateau. One sample is
// taken every cycle while the result side keeps up; the rate is set by the
// single compare and state update stage. The user must write the keep mode
// register via cfg_wr_en/cfg_wr_data only while the block is idle; the block
// does not enforce it. Reset clears the mode to keep all extrema, empties both
// registers and forgets the plateau, so the first sample starts a record. When
// the receiver stalls, the result is held, one more sample may wait in the
// input register, and sample_ready then drops until the result moves.
// ----------------------------------------------------------------------------
module plateau_aware_extrema_detector_unit #(
    parameter int SAMPLE_WIDTH = pead_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic        [pead_pkg::MODE_W-1:0]   cfg_wr_data,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_value,
    input  logic        [pead_pkg::COORD_W-1:0]  coordinate,
    input  logic        [pead_pkg::ID_W-1:0]     sequence_id,
    input  logic                                 record_start,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic        [pead_pkg::COORD_W-1:0]  extremum_position,
    output logic signed [SAMPLE_WIDTH-1:0]       extremum_value,
    output logic                                 is_maximum,
    output logic        [pead_pkg::ID_W-1:0]     out_sequence_id
);
    import pead_pkg::*;

    stage_ctl_t                     stage_ctl;
    logic signed [SAMPLE_WIDTH-1:0] stage_value;
    logic [COORD_W-1:0]             stage_coord;
    logic [ID_W-1:0]                stage_id;
    logic                           advance;

    pead_in_stage #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_value (sample_value),
        .coordinate   (coordinate),
        .sequence_id  (sequence_id),
        .record_start (record_start),
        .advance      (advance),
        .stage_ctl    (stage_ctl),
        .stage_value  (stage_value),
        .stage_coord  (stage_coord),
        .stage_id     (stage_id)
    );

    pead_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .stage_ctl         (stage_ctl),
        .stage_value       (stage_value),
        .stage_coord       (stage_coord),
        .stage_id          (stage_id),
        .advance           (advance),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .extremum_position (extremum_position),
        .extremum_value    (extremum_value),
        .is_maximum        (is_maximum),
        .out_sequence_id   (out_sequence_id)
    );

endmodule

@@ sv/pead_checker.sv @@
// ----------------------------------------------------------------------------
// Extrema detector port checker
// Watches the top level ports for result filtering, flow and hold rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pead_checker #(
    parameter int SAMPLE_WIDTH = pead_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_wr_en,
    input logic        [pead_pkg::MODE_W-1:0]   cfg_wr_data,
    input logic                                 sample_valid,
    input logic                                 sample_ready,
    input logic signed [SAMPLE_WIDTH-1:0]       sample_value,
    input logic        [pead_pkg::COORD_W-1:0]  coordinate,
    input logic        [pead_pkg::ID_W-1:0]     sequence_id,
    input logic                                 record_start,
    input logic                                 result_valid,
    input logic                                 result_ready,
    input logic        [pead_pkg::COORD_W-1:0]  extremum_position,
    input logic signed [SAMPLE_WIDTH-1:0]       extremum_value,
    input logic                                 is_maximum,
    input logic        [pead_pkg::ID_W-1:0]     out_sequence_id
);
    import pead_pkg::*;

    logic [MODE_W-1:0]                    mode_reg;
    logic                                 max_shown;
    logic                                 min_shown;
    logic                                 result_stall;
    logic                                 sample_stall;
    logic [COORD_W+SAMPLE_WIDTH+ID_W:0]   result_word;
    logic [SAMPLE_WIDTH+COORD_W+ID_W:0]   sample_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= KEEP_ALL;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    assign max_shown    = result_valid && is_maximum;
    assign min_shown    = result_valid && !is_maximum;
    assign result_stall = result_valid && !result_ready;
    assign sample_stall = sample_valid && !sample_ready;
    assign result_word  = {extremum_position, extremum_value, is_maximum, out_sequence_id};
    assign sample_word  = {sample_value, coordinate, sequence_id, record_start};

    `PEAD_ASSERT(a_no_dropped_max, clk, rst_n, max_shown, mode_reg != KEEP_DROP_MAX)
    `PEAD_ASSERT(a_no_dropped_min, clk, rst_n, min_shown, mode_reg != KEEP_DROP_MIN)
    `PEAD_ASSERT(a_ready_when_drained, clk, rst_n, result_ready, sample_ready)
    `PEAD_ASSERT_NEXT(a_result_held, clk, rst_n, result_stall, result_valid && $stable(result_word))
    `PEAD_ASSERT_NEXT(a_sample_held, clk, rst_n, sample_stall, sample_valid && $stable(sample_word))

endmodule

bind plateau_aware_extrema_detector_unit pead_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_pead_checker (.*);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Plateau-aware extrema detector testbench
// Streams records of samples into the detector with random idle cycles on the
// sample side and random stalls on the result side. A local model of the
// plateau tracker predicts every extremum at the sample transfer, and each
// result transfer is checked field by field against the oldest prediction.
// Directed records cover the special cases and every keep mode, then random
// records run in phases with the keep mode rewritten between them.
// ----------------------------------------------------------------------------
module testbench;

    import pead_pkg::*;

    localparam int SW              = SAMPLE_WIDTH_DEF;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASE_SAMPLES   = 230;
    localparam int MAX_REPORTED    = 10;

    localparam logic [MODE_W-1:0] KEEP_UNUSED = 2'd3;

    localparam logic signed [SW-1:0] VALUE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] VALUE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [COORD_W-1:0]   COORD_TOP = {COORD_W{1'b1}};

    typedef struct {
        logic [COORD_W-1:0]   pos;
        logic signed [SW-1:0] val;
        logic                 is_max;
        logic [ID_W-1:0]      id;
    } extremum_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [MODE_W-1:0]          cfg_wr_data = '0;
    logic                       sample_valid = 1'b0;
    logic                       sample_ready;
    logic signed [SW-1:0]       sample_value = '0;
    logic [COORD_W-1:0]         coordinate = '0;
    logic [ID_W-1:0]            sequence_id = '0;
    logic                       record_start = 1'b0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic [COORD_W-1:0]         extremum_position;
    logic signed [SW-1:0]       extremum_value;
    logic                       is_maximum;
    logic [ID_W-1:0]            out_sequence_id;

    bit          sender_idle_on   = 1'b1;
    bit          receiver_stall_on = 1'b1;
    int unsigned error_count      = 0;
    int unsigned samples_done     = 0;
    int unsigned extrema_checked  = 0;
    int unsigned mode_writes      = 0;

    logic [MODE_W-1:0]    keep_mode_q;
    logic signed [SW-1:0] before_val_q;
    logic signed [SW-1:0] plateau_val_q;
    logic [COORD_W-1:0]   before_coord_q;
    logic [COORD_W-1:0]   last_coord_q;
    logic [SEEN_W-1:0]    levels_seen_q;

    extremum_t pending_extrema[$];

    plateau_aware_extrema_detector_unit #(
        .SAMPLE_WIDTH (SW)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .sample_valid      (sample_valid),
        .sample_ready      (sample_ready),
        .sample_value      (sample_value),
        .coordinate        (coordinate),
        .sequence_id       (sequence_id),
        .record_start      (record_start),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .extremum_position (extremum_position),
        .extremum_value    (extremum_value),
        .is_maximum        (is_maximum),
        .out_sequence_id   (out_sequence_id)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_ready <= !receiver_stall_on || ($urandom_range(0, 99) >= 34);
    end

    function void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTED)
            $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void clear_plateau_tracker();
        keep_mode_q    = KEEP_ALL;
        before_val_q   = '0;
        plateau_val_q  = '0;
        before_coord_q = '0;
        last_coord_q   = '0;
        levels_seen_q  = SEEN_NONE;
    endfunction

    function void track_sample(input logic signed [SW-1:0] val, input logic [COORD_W-1:0] coord,
                               input logic [ID_W-1:0] id, input logic start);
        logic             hit;
        logic             is_max;
        logic [COORD_W:0] coord_sum;
        extremum_t        found;
        hit    = 1'b0;
        is_max = 1'b0;
        if (start || levels_seen_q == SEEN_NONE)
        begin
            plateau_val_q  = val;
            before_val_q   = val;
            before_coord_q = coord;
            last_coord_q   = coord;
            levels_seen_q  = SEEN_ONE;
        end
        else if (val == plateau_val_q)
        begin
            last_coord_q = coord;
        end
        else
        begin
            if (levels_seen_q == SEEN_TWO)
            begin
                if (plateau_val_q > before_val_q && plateau_val_q > val)
                begin
                    hit    = 1'b1;
                    is_max = 1'b1;
                end
                else if (plateau_val_q < before_val_q && plateau_val_q < val)
                begin
                    hit = 1'b1;
                end
                if (hit && !(!is_max && keep_mode_q == KEEP_DROP_MIN)
                        && !(is_max && keep_mode_q == KEEP_DROP_MAX))
                begin
                    coord_sum    = {1'b0, before_coord_q} + {1'b0, coord};
                    found.pos    = coord_sum[COORD_W:1];
                    found.val    = plateau_val_q;
                    found.is_max = is_max;
                    found.id     = id;
                    pending_extrema.push_back(found);
                end
            end
            before_val_q   = plateau_val_q;
            before_coord_q = last_coord_q;
            plateau_val_q  = val;
            last_coord_q   = coord;
            levels_seen_q  = SEEN_TWO;
        end
    endfunction

    function void check_extremum();
        extremum_t want;
        if (pending_extrema.size() == 0)
        begin
            note_error($sformatf("unexpected extremum: position %0d value %0d max %0b id %0h",
                                 extremum_position, extremum_value, is_maximum,
                                 out_sequence_id));
        end
        else
        begin
            want = pending_extrema.pop_front();
            extrema_checked++;
            if (extremum_position !== want.pos)
                note_error($sformatf("position: expected %0d, actual %0d",
                                     want.pos, extremum_position));
            if (extremum_value !== want.val)
                note_error($sformatf("value: expected %0d, actual %0d",
                                     want.val, extremum_value));
            if (is_maximum !== want.is_max)
                note_error($sformatf("is_maximum: expected %0b, actual %0b",
                                     want.is_max, is_maximum));
            if (out_sequence_id !== want.id)
                note_error($sformatf("sequence id: expected %0h, actual %0h",
                                     want.id, out_sequence_id));
        end
    endfunction

    // Every transfer is seen here: samples feed the tracker before results are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                keep_mode_q = cfg_wr_data;
            if (sample_valid && sample_ready)
            begin
                samples_done++;
                track_sample(sample_value, coordinate, sequence_id, record_start);
            end
            if (result_valid && result_ready)
                check_extremum();
        end
    end

    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL plateau_aware_extrema_detector_unit");
        $finish;
    end

    task automatic send_sample(input logic signed [SW-1:0] val, input logic [COORD_W-1:0] coord,
                               input logic [ID_W-1:0] id, input logic start);
        int unsigned gap;
        gap = 0;
        if (sender_idle_on)
            while ($urandom_range(0, 99) < 34 && gap < 64)
                gap++;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_value <= val;
        coordinate   <= coord;
        sequence_id  <= id;
        record_start <= start;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        sample_valid <= 1'b0;
        while (pending_extrema.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_keep_mode(input logic [MODE_W-1:0] mode);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mode_writes++;
    endtask

    // A record is a random level with small steps around it, so that plateaus,
    // peaks and valleys all occur; a few samples jump anywhere.
    task automatic send_record(input int unsigned len);
        logic signed [SW-1:0] base;
        logic signed [SW-1:0] val;
        logic [COORD_W-1:0]   coord;
        logic [ID_W-1:0]      id;
        logic                 start;
        int                   offset;
        int unsigned          pick;
        base  = $urandom;
        val   = base;
        coord = COORD_W'($urandom_range(0, 32'h7FFF_FFFF));
        id    = ID_W'($urandom_range(0, 16'hFFFF));
        for (int unsigned i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                offset = int'($urandom_range(0, 6)) - 3;
                val    = base + offset;
            end
            else if (pick < 80)
                val = $urandom;
            else if (pick < 83)
                val = ($urandom_range(0, 1) != 0) ? VALUE_MAX : VALUE_MIN;
            if ($urandom_range(0, 19) == 0)
                coord = COORD_W'($urandom_range(0, 32'h7FFF_FFFF));
            else
                coord = coord + COORD_W'($urandom_range(0, 3));
            if ($urandom_range(0, 49) == 0)
                id = ID_W'($urandom_range(0, 16'hFFFF));
            start = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) == 0);
            send_sample(val, coord, id, start);
        end
    endtask

    task automatic test_special_shapes();
        send_sample(5, 10, 16'h0000, 1'b0);
        send_sample(9, 11, 16'h0000, 1'b0);
        send_sample(9, 12, 16'h0000, 1'b0);
        send_sample(3, 13, 16'h0000, 1'b0);
        send_sample(7, 14, 16'hFFFF, 1'b0);
        send_sample(VALUE_MAX, COORD_TOP, 16'hFFFF, 1'b0);
        send_sample(VALUE_MIN, COORD_TOP, 16'hFFFF, 1'b0);
        send_sample(VALUE_MAX, 0, 16'h5A5A, 1'b0);
        send_sample(4, 100, 16'h1234, 1'b1);
        send_sample(4, 101, 16'h1234, 1'b0);
        send_sample(7, 102, 16'h1234, 1'b0);
        send_sample(7, 103, 16'h1234, 1'b0);
        send_sample(2, 50, 16'hA5A5, 1'b0);
        send_sample(2, 51, 16'hABCD, 1'b1);
    endtask

    task automatic test_keep_modes();
        logic [MODE_W-1:0] modes [3];
        modes = '{KEEP_DROP_MIN, KEEP_DROP_MAX, KEEP_UNUSED};
        foreach (modes[m])
        begin
            write_keep_mode(modes[m]);
            send_sample(0, 200, 16'h0042, 1'b1);
            send_sample(5, 201, 16'h0042, 1'b0);
            send_sample(0, 202, 16'h0042, 1'b0);
            send_sample(5, 203, 16'h0042, 1'b0);
        end
    endtask

    task automatic test_random_records();
        logic [MODE_W-1:0] modes [8];
        int unsigned       target;
        modes = '{KEEP_ALL, KEEP_DROP_MIN, KEEP_DROP_MAX, KEEP_UNUSED,
                  KEEP_ALL, KEEP_DROP_MAX, KEEP_DROP_MIN, KEEP_ALL};
        modes[5] = MODE_W'($urandom_range(0, 3));
        foreach (modes[p])
        begin
            write_keep_mode(modes[p]);
            sender_idle_on    = (p != 3);
            receiver_stall_on = (p != 3);
            target = samples_done + PHASE_SAMPLES;
            while (samples_done < target)
            begin
                send_record($urandom_range(1, 14));
                if (p == 6 && $urandom_range(0, 19) == 0)
                    drain_results();
            end
        end
        sender_idle_on    = 1'b1;
        receiver_stall_on = 1'b1;
    endtask

    initial
    begin
        clear_plateau_tracker();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_shapes();
        test_keep_modes();
        test_random_records();
        drain_results();
        $display("Summary: %0d samples transferred under %0d keep mode writes, %0d extrema checked.",
                 samples_done, mode_writes, extrema_checked);
        $display("Summary: %0d mismatches found.", error_count);
        if (error_count == 0)
            $display("PASS plateau_aware_extrema_detector_unit");
        else
            $display("FAIL plateau_aware_extrema_detector_unit");
        $finish;
    end

endmodule
